// ===== rtl/core/trds_pkg.sv =====
// Shared constants, types and command structures of the touch report decoder.
package trds_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int BYTE_W      = 8;
    localparam int LOW_BITS    = 7;
    localparam int RAW_W       = 15;
    localparam int COORD_W     = 16;
    localparam int DIFF_W      = RAW_W + 1;
    localparam int PROD_W      = DIFF_W + RAW_W;
    localparam int MAG_W       = PROD_W - 1;
    localparam int REM_W       = RAW_W + 1;
    localparam int CNT_W       = $clog2(MAG_W + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [BYTE_W-1:0] NO_DATA_MARK = 8'h4D;
    localparam int                PEN_BIT      = 0;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H    = 3'd5;

    localparam logic [RAW_W-1:0] RST_RAW_X_MIN = 15'd0;
    localparam logic [RAW_W-1:0] RST_RAW_X_MAX = 15'd4095;
    localparam logic [RAW_W-1:0] RST_RAW_Y_MIN = 15'd0;
    localparam logic [RAW_W-1:0] RST_RAW_Y_MAX = 15'd4095;
    localparam logic [RAW_W-1:0] RST_SCREEN_W  = 15'd320;
    localparam logic [RAW_W-1:0] RST_SCREEN_H  = 15'd240;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef logic [RAW_W-1:0]          t_raw;
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic             store_byte;
        logic [POS_W-1:0] pos;
        logic             emit_nodata;
        logic             load_axis;
        logic             axis;
        logic             mul;
        logic             div_init;
        logic             div_step;
        logic             fin;
    } t_dp_cmd;

    typedef struct packed {
        logic header_nodata;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/core/trds_ifs.sv =====
// Handshake interfaces for the report byte, result and configuration channels.
interface trds_in_if;
    logic                       valid;
    logic                       ready;
    logic [trds_pkg::BYTE_W-1:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface trds_out_if;
    logic              valid;
    logic              ready;
    logic              no_data;
    logic              pen_down;
    trds_pkg::t_coord  screen_x;
    trds_pkg::t_coord  screen_y;
    logic              span_error;

    modport source(output valid, output no_data, output pen_down, output screen_x,
                   output screen_y, output span_error, input ready);
    modport sink(input valid, input no_data, input pen_down, input screen_x,
                 input screen_y, input span_error, output ready);
endinterface

interface trds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [trds_pkg::CFG_IDX_W-1:0] index;
    trds_pkg::t_raw                 data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/trds_dp.sv =====
// Datapath: frame store, calibration registers, multiplier, divider and result register.
module trds_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trds_pkg::t_dp_cmd  i_cmd,
    output trds_pkg::t_dp_stat o_stat,
    input  logic [trds_pkg::BYTE_W-1:0] i_rx_byte,
    trds_cfg_if.sink           i_cfg,
    trds_out_if.source         o_out
);
    import trds_pkg::*;

    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(2 ** (COORD_W - 1) - 1);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(2 ** (COORD_W - 1));

    t_raw r_x_min, r_x_max, r_y_min, r_y_max, r_scr_w, r_scr_h;

    logic [BYTE_W-1:0] r_frame [FRAME_BYTES];

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [DIFF_W-1:0] r_span;
    t_raw                     r_size;
    logic signed [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]         r_num;
    t_raw                     r_den;
    logic [REM_W-1:0]         r_rem;
    logic                     r_neg;
    logic                     r_zero;

    logic   r_out_valid;
    logic   r_out_no_data;
    logic   r_out_pen;
    t_coord r_out_x;
    t_coord r_out_y;
    logic   r_out_err;

    t_raw                     w_raw_x, w_raw_y, w_raw, w_lo, w_hi, w_size;
    logic signed [PROD_W-1:0] w_diff_ext, w_size_ext, w_prod;
    logic [PROD_W-1:0]        w_prod_abs;
    logic [DIFF_W-1:0]        w_span_abs;
    logic [REM_W-1:0]         w_shift;
    logic                     w_ge;
    t_coord                   w_sat;

    assign i_cfg.ready = 1'b1;

    assign w_raw_x = {r_frame[2], r_frame[1][LOW_BITS-1:0]};
    assign w_raw_y = {r_frame[4], r_frame[3][LOW_BITS-1:0]};
    assign w_raw   = (i_cmd.axis == AXIS_Y) ? w_raw_y : w_raw_x;
    assign w_lo    = (i_cmd.axis == AXIS_Y) ? r_y_min : r_x_min;
    assign w_hi    = (i_cmd.axis == AXIS_Y) ? r_y_max : r_x_max;
    assign w_size  = (i_cmd.axis == AXIS_Y) ? r_scr_h : r_scr_w;

    assign w_diff_ext = {{(PROD_W - DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
    assign w_size_ext = $signed({{(PROD_W - RAW_W){1'b0}}, r_size});
    assign w_prod     = w_diff_ext * w_size_ext;

    assign w_prod_abs = r_prod[PROD_W-1] ? $unsigned(-r_prod) : $unsigned(r_prod);
    assign w_span_abs = r_span[DIFF_W-1] ? $unsigned(-r_span) : $unsigned(r_span);

    // One restoring step: bring in the next numerator bit, subtract if it fits.
    assign w_shift = {r_rem[REM_W-2:0], r_num[MAG_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    // After the last step r_num holds the quotient magnitude.
    always_comb begin
        if (r_zero) begin
            w_sat = '0;
        end else if (!r_neg) begin
            w_sat = (r_num > POS_LIMIT) ? t_coord'(POS_LIMIT[COORD_W-1:0])
                                        : $signed(r_num[COORD_W-1:0]);
        end else begin
            w_sat = (r_num > NEG_LIMIT) ? t_coord'(NEG_LIMIT[COORD_W-1:0])
                                        : -$signed(r_num[COORD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min     <= RST_RAW_X_MIN;
            r_x_max     <= RST_RAW_X_MAX;
            r_y_min     <= RST_RAW_Y_MIN;
            r_y_max     <= RST_RAW_Y_MAX;
            r_scr_w     <= RST_SCREEN_W;
            r_scr_h     <= RST_SCREEN_H;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_RAW_X_MIN: r_x_min <= i_cfg.data;
                    CFG_RAW_X_MAX: r_x_max <= i_cfg.data;
                    CFG_RAW_Y_MIN: r_y_min <= i_cfg.data;
                    CFG_RAW_Y_MAX: r_y_max <= i_cfg.data;
                    CFG_SCREEN_W:  r_scr_w <= i_cfg.data;
                    CFG_SCREEN_H:  r_scr_h <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.emit_nodata || (i_cmd.fin && i_cmd.axis == AXIS_Y)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            r_frame[i_cmd.pos] <= i_rx_byte;
        end
        if (i_cmd.load_axis) begin
            r_diff <= $signed({1'b0, w_raw}) - $signed({1'b0, w_lo});
            r_span <= $signed({1'b0, w_hi}) - $signed({1'b0, w_lo});
            r_size <= w_size;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_prod[PROD_W-1] ^ r_span[DIFF_W-1];
            r_zero <= (r_span == '0);
            r_num  <= w_prod_abs[MAG_W-1:0];
            r_den  <= w_span_abs[RAW_W-1:0];
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_num <= {r_num[MAG_W-2:0], w_ge};
        end
        if (i_cmd.emit_nodata) begin
            r_out_no_data <= 1'b1;
            r_out_pen     <= 1'b0;
            r_out_x       <= '0;
            r_out_y       <= '0;
            r_out_err     <= 1'b0;
        end
        if (i_cmd.fin) begin
            if (i_cmd.axis == AXIS_X) begin
                r_out_x   <= w_sat;
                r_out_err <= r_zero;
            end else begin
                r_out_y       <= w_sat;
                r_out_err     <= r_out_err | r_zero;
                r_out_no_data <= 1'b0;
                r_out_pen     <= r_frame[0][PEN_BIT];
            end
        end
    end

    assign o_stat.header_nodata = (r_frame[0] == NO_DATA_MARK);
    assign o_stat.out_busy      = r_out_valid;

    assign o_out.valid      = r_out_valid;
    assign o_out.no_data    = r_out_no_data;
    assign o_out.pen_down   = r_out_pen;
    assign o_out.screen_x   = r_out_x;
    assign o_out.screen_y   = r_out_y;
    assign o_out.span_error = r_out_err;

endmodule

// ===== rtl/core/trds_ctrl.sv =====
// Controller: frame byte counting and sequencing of the two axis scalings.
module trds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  trds_pkg::t_dp_stat i_stat,
    output trds_pkg::t_dp_cmd  o_cmd
);
    import trds_pkg::*;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_LOAD,
        S_MUL,
        S_INIT,
        S_DIV,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [POS_W-1:0] r_pos;
    logic             r_axis;
    logic [CNT_W-1:0] r_cnt;

    logic w_last;
    logic w_accept;

    assign w_last = (r_pos == POS_W'(FRAME_BYTES - 1));

    // The closing byte of a frame waits until the previous result has been taken.
    assign o_in_ready = (r_state == S_COLLECT) && !(w_last && i_stat.out_busy);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.store_byte  = w_accept;
        o_cmd.pos         = r_pos;
        o_cmd.emit_nodata = w_accept && w_last && i_stat.header_nodata;
        o_cmd.axis        = r_axis;
        o_cmd.load_axis   = (r_state == S_LOAD);
        o_cmd.mul         = (r_state == S_MUL);
        o_cmd.div_init    = (r_state == S_INIT);
        o_cmd.div_step    = (r_state == S_DIV);
        o_cmd.fin         = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_pos   <= '0;
            r_axis  <= AXIS_X;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_COLLECT: begin
                    if (w_accept) begin
                        if (w_last) begin
                            r_pos <= '0;
                            if (!i_stat.header_nodata) begin
                                r_axis  <= AXIS_X;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                S_LOAD: r_state <= S_MUL;
                S_MUL:  r_state <= S_INIT;
                S_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MAG_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_axis == AXIS_X) begin
                        r_axis  <= AXIS_Y;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

endmodule

// ===== rtl/core/touch_report_decode_scale.sv =====
// Bytes 1 to 4 of a frame are taken one a cycle while the decoder is collecting; a no-data frame's
// result is valid in the cycle after its fifth byte is taken. For a coordinate frame, each axis takes
// a load, a multiply, a divider set-up, 30 steps of the shared one-bit-a-step divider and a
// saturation step, and the result is valid once the Y axis has finished.
// The fifth byte is held off while an earlier result waits on the output register.
// Synchronous active-low reset restores the calibration defaults and waits for a header byte.
module touch_report_decode_scale (
    input  logic       i_clk,
    input  logic       i_rst_n,
    trds_in_if.sink    i_in,
    trds_out_if.source o_out,
    trds_cfg_if.sink   i_cfg
);
    import trds_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    trds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    trds_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_rx_byte (i_in.rx_byte),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/core/trds_checker.sv =====
// Port-level checks on the result channel of the decoder, bound to the top level.
module trds_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_no_data,
    input logic             i_pen_down,
    input trds_pkg::t_coord i_screen_x,
    input trds_pkg::t_coord i_screen_y,
    input logic             i_span_error
);
    import trds_pkg::*;

    // A result that has not been taken stays offered.
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_no_data, i_pen_down, i_screen_x,
                                                 i_screen_y, i_span_error}))
        else $error("result changed while stalled");

    // A no-data result carries nothing else.
    a_nodata_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_no_data |-> !i_pen_down && !i_span_error
                                     && i_screen_x == '0 && i_screen_y == '0)
        else $error("no-data result carries coordinate fields");

    // A zero span forces that axis to zero.
    a_span_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_span_error |-> i_screen_x == '0 || i_screen_y == '0)
        else $error("span error without a zeroed coordinate");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

endmodule

bind touch_report_decode_scale trds_checker u_trds_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_no_data    (o_out.no_data),
    .i_pen_down   (o_out.pen_down),
    .i_screen_x   (o_out.screen_x),
    .i_screen_y   (o_out.screen_y),
    .i_span_error (o_out.span_error)
);
